// ===== hdl/chgs_pkg.sv =====
package chgs_pkg;
    localparam int MaxPoints = 64;
    localparam int CoordBits = 16;
    localparam int IdxBits   = $clog2(MaxPoints);
    localparam int CntBits   = $clog2(MaxPoints + 1);
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int CrossBits = ProdBits + 1;
    localparam int DistBits  = DiffBits + 1;
    localparam int QueueDepth = 4;
    localparam int QIdxBits  = $clog2(QueueDepth);

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic [IdxBits-1:0]          t_idx;
    typedef logic [CntBits-1:0]          t_cnt;

    // one entry of the queue between loader and hull engine
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_qent;
endpackage

// ===== hdl/convex_hull_graham_scan_unit.sv =====
// Convex hull engine (Graham scan) behind queue-style ports.
// Input: drive i_point_x/i_point_y/i_last_point with push; a request is taken
// when full is low. i_last_point closes the set and starts the hull run.
// Output: while empty is low o_hull_* and o_overflow show the oldest vertex;
// pop takes it. Vertices come counterclockwise from the pivot (lowest, then
// rightmost point); o_hull_last marks the final one and o_overflow that points
// beyond 64 were dropped from the set.
// Points load one per cycle through a 4-entry queue while the engine is in its
// load state; the pivot is tracked as they arrive. After the last point the
// insertion sort makes up to N*(N-1)/2 comparisons, the stack scan makes at
// most 2N turn tests, and emission then loads out one vertex at a time.
// Every step waits on one registered store read or the multiplier pair.
// No new set is taken until the last vertex of the previous one is loaded out.
// While the receiver stalls the pending vertex holds and the engine waits;
// the input queue fills and then full rises.
// Synchronous active-low reset empties both sides and the point store
// count; store contents are left as they are.
module convex_hull_graham_scan_unit
    import chgs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   push,
    output logic   full,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    input  logic   i_last_point,
    output logic   empty,
    input  logic   pop,
    output t_coord o_hull_x,
    output t_coord o_hull_y,
    output logic   o_hull_last,
    output logic   o_overflow
);
    logic  w_qv, w_take;
    t_qent w_qd;

    chgs_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_point_x, .i_point_y, .i_last_point,
        .o_q_valid(w_qv), .o_q_data(w_qd), .i_q_take(w_take)
    );

    chgs_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_data(w_qd), .o_q_take(w_take),
        .o_empty(empty), .i_pop(pop), .o_hull_x, .o_hull_y, .o_hull_last, .o_overflow
    );
endmodule

// ===== hdl/chgs_front.sv =====
module chgs_front
    import chgs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    input  logic   i_last_point,
    output logic   o_q_valid,
    output t_qent  o_q_data,
    input  logic   i_q_take
);
    t_qent               r_mem [QueueDepth];
    logic [QIdxBits-1:0] r_wp, r_rp;
    logic [QIdxBits:0]   r_cnt;
    logic                w_wr, w_rd;

    assign o_full    = (r_cnt == (QIdxBits+1)'(QueueDepth));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_mem[r_rp];
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= '{x: i_point_x, y: i_point_y, last: i_last_point};
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QIdxBits+1)'(w_wr) - (QIdxBits+1)'(w_rd);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QIdxBits+1)'(QueueDepth)) else $error("queue count over depth");
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_cnt != '0) else $error("full queue emptied without read");
    a_rd_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_rd |=> $stable(r_rp)) else $error("read pointer moved without read");
endmodule

// ===== hdl/chgs_back.sv =====
module chgs_back
    import chgs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_qent  i_q_data,
    output logic   o_q_take,
    output logic   o_empty,
    input  logic   i_pop,
    output t_coord o_hull_x,
    output t_coord o_hull_y,
    output logic   o_hull_last,
    output logic   o_overflow
);
    localparam logic [4:0] S_LOAD   = 5'd0,
                           S_SORT_A = 5'd1, S_SORT_B = 5'd2, S_SORT_C = 5'd3,
                           S_SORT_D = 5'd4, S_SORT_E = 5'd5, S_SORT_F = 5'd6,
                           S_SCAN_A = 5'd7, S_SCAN_B = 5'd8, S_SCAN_C = 5'd9,
                           S_SCAN_D = 5'd10, S_SCAN_E = 5'd11, S_SCAN_F = 5'd12,
                           S_SCAN_G = 5'd13, S_SCAN_H = 5'd14,
                           S_EMIT_A = 5'd15, S_EMIT_B = 5'd16, S_EMIT_C = 5'd17;

    t_coord r_px [MaxPoints];
    t_coord r_py [MaxPoints];
    t_idx   r_ord [MaxPoints];
    t_idx   r_stk [MaxPoints];

    logic [4:0] r_st;
    t_cnt   r_n, r_i, r_j, r_sorted, r_sp;
    logic   r_ovf, r_ovf_out;
    t_coord r_pvx, r_pvy;
    t_idx   r_piv, r_cur, r_prev;
    t_coord r_ax, r_ay, r_bx, r_by;
    // registered store read data, also the third cross operand
    t_coord r_rx, r_ry;
    t_idx   r_od, r_sd;
    logic signed [ProdBits-1:0] r_m1, r_m2;
    logic   r_out_v;
    t_coord r_ox, r_oy;
    logic   r_olast, r_oovf;

    // operands: cross of (b-a) x (c-a), c taken from the store read register
    logic signed [DiffBits-1:0] w_d1x, w_d1y, w_d2x, w_d2y;
    logic signed [CrossBits-1:0] w_cross;
    logic [DistBits-1:0] w_db, w_dc;
    t_idx   w_i, w_j, w_sp;
    logic   w_new_piv, w_load_out;

    assign w_d1x = DiffBits'(r_bx) - DiffBits'(r_ax);
    assign w_d1y = DiffBits'(r_by) - DiffBits'(r_ay);
    assign w_d2x = DiffBits'(r_rx) - DiffBits'(r_ax);
    assign w_d2y = DiffBits'(r_ry) - DiffBits'(r_ay);
    assign w_cross = CrossBits'(r_m1) - CrossBits'(r_m2);
    assign w_db = DistBits'(w_d1x < 0 ? -w_d1x : w_d1x)
                + DistBits'(w_d1y < 0 ? -w_d1y : w_d1y);
    assign w_dc = DistBits'(w_d2x < 0 ? -w_d2x : w_d2x)
                + DistBits'(w_d2y < 0 ? -w_d2y : w_d2y);

    assign w_i  = r_i[IdxBits-1:0];
    assign w_j  = r_j[IdxBits-1:0];
    assign w_sp = r_sp[IdxBits-1:0];

    // pivot: lowest, then rightmost; the first of equal points is kept
    assign w_new_piv = (r_n == '0) || (i_q_data.y < r_pvy) ||
                       (i_q_data.y == r_pvy && i_q_data.x > r_pvx);
    assign w_load_out = (r_st == S_EMIT_C) && (!r_out_v || i_pop);

    assign o_q_take = (r_st == S_LOAD) && i_q_valid;
    assign o_empty = !r_out_v;
    assign o_hull_x = r_ox;
    assign o_hull_y = r_oy;
    assign o_hull_last = r_olast;
    assign o_overflow = r_oovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_n <= '0;
            r_sp <= '0;
            r_ovf <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
            unique case (r_st)
                S_LOAD: if (i_q_valid) begin
                    if (r_n < t_cnt'(MaxPoints)) begin
                        r_px[r_n[IdxBits-1:0]] <= i_q_data.x;
                        r_py[r_n[IdxBits-1:0]] <= i_q_data.y;
                        r_n <= r_n + 1'b1;
                        if (w_new_piv) begin
                            r_piv <= r_n[IdxBits-1:0];
                            r_pvx <= i_q_data.x;
                            r_pvy <= i_q_data.y;
                        end
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if (i_q_data.last) begin
                        r_st <= S_SORT_A;
                        r_i <= '0;
                        r_sorted <= '0;
                        r_ovf_out <= r_ovf || (r_n >= t_cnt'(MaxPoints));
                    end
                end
                // insertion sort; each comparison runs through states S_SORT_C to S_SORT_F
                S_SORT_A: begin
                    if (r_i >= r_n) begin
                        r_st <= S_SCAN_A;
                        r_stk[0] <= r_piv;
                        r_sp <= t_cnt'(1);
                        r_i <= '0;
                    end else begin
                        r_rx <= r_px[w_i];
                        r_ry <= r_py[w_i];
                        r_st <= S_SORT_B;
                    end
                end
                S_SORT_B: begin
                    if (r_rx == r_pvx && r_ry == r_pvy) begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_SORT_A;
                    end else begin
                        r_ax <= r_pvx; r_ay <= r_pvy;
                        r_bx <= r_rx; r_by <= r_ry;
                        r_cur <= w_i;
                        r_j <= r_sorted;
                        r_st <= S_SORT_C;
                    end
                end
                S_SORT_C: begin
                    if (r_j == '0) begin
                        r_ord[0] <= r_cur;
                        r_sorted <= r_sorted + 1'b1;
                        r_i <= r_i + 1'b1;
                        r_st <= S_SORT_A;
                    end else begin
                        r_od <= r_ord[w_j - 1'b1];
                        r_st <= S_SORT_D;
                    end
                end
                S_SORT_D: begin
                    r_prev <= r_od;
                    r_rx <= r_px[r_od];
                    r_ry <= r_py[r_od];
                    r_st <= S_SORT_E;
                end
                S_SORT_E: begin
                    r_m1 <= w_d1x * w_d2y;
                    r_m2 <= w_d1y * w_d2x;
                    r_st <= S_SORT_F;
                end
                S_SORT_F: begin
                    if (w_cross > 0 || (w_cross == 0 && w_db < w_dc)) begin
                        r_ord[w_j] <= r_prev;
                        r_j <= r_j - 1'b1;
                        r_st <= S_SORT_C;
                    end else begin
                        r_ord[w_j] <= r_cur;
                        r_sorted <= r_sorted + 1'b1;
                        r_i <= r_i + 1'b1;
                        r_st <= S_SORT_A;
                    end
                end
                S_SCAN_A: begin
                    if (r_i >= r_sorted) begin
                        r_st <= S_EMIT_A;
                        r_i <= '0;
                    end else begin
                        r_od <= r_ord[w_i];
                        r_st <= S_SCAN_B;
                    end
                end
                S_SCAN_B: begin
                    r_cur <= r_od;
                    r_st <= S_SCAN_C;
                end
                S_SCAN_C: begin
                    if (r_sp < t_cnt'(2)) begin
                        r_stk[w_sp] <= r_cur;
                        r_sp <= r_sp + 1'b1;
                        r_i <= r_i + 1'b1;
                        r_st <= S_SCAN_A;
                    end else begin
                        r_sd <= r_stk[w_sp - t_idx'(2)];
                        r_st <= S_SCAN_D;
                    end
                end
                // fetch second, top and candidate in turn; candidate ends in r_rx
                S_SCAN_D: begin
                    r_rx <= r_px[r_sd];
                    r_ry <= r_py[r_sd];
                    r_sd <= r_stk[w_sp - t_idx'(1)];
                    r_st <= S_SCAN_E;
                end
                S_SCAN_E: begin
                    r_ax <= r_rx; r_ay <= r_ry;
                    r_rx <= r_px[r_sd];
                    r_ry <= r_py[r_sd];
                    r_st <= S_SCAN_F;
                end
                S_SCAN_F: begin
                    r_bx <= r_rx; r_by <= r_ry;
                    r_rx <= r_px[r_cur];
                    r_ry <= r_py[r_cur];
                    r_st <= S_SCAN_G;
                end
                S_SCAN_G: begin
                    r_m1 <= w_d1x * w_d2y;
                    r_m2 <= w_d1y * w_d2x;
                    r_st <= S_SCAN_H;
                end
                S_SCAN_H: begin
                    if (w_cross > 0) begin
                        if (r_sp < t_cnt'(MaxPoints)) begin
                            r_stk[w_sp] <= r_cur;
                            r_sp <= r_sp + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                        r_st <= S_SCAN_A;
                    end else begin
                        r_sp <= r_sp - 1'b1;
                        r_st <= S_SCAN_C;
                    end
                end
                S_EMIT_A: begin
                    r_sd <= r_stk[w_i];
                    r_st <= S_EMIT_B;
                end
                S_EMIT_B: begin
                    r_rx <= r_px[r_sd];
                    r_ry <= r_py[r_sd];
                    r_st <= S_EMIT_C;
                end
                S_EMIT_C: begin
                    if (w_load_out) begin
                        r_ox <= r_rx;
                        r_oy <= r_ry;
                        r_olast <= (r_i + 1'b1 == r_sp);
                        r_oovf <= r_ovf_out;
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_sp) begin
                            r_st <= S_LOAD;
                            r_n <= '0;
                            r_ovf <= 1'b0;
                        end else begin
                            r_st <= S_EMIT_A;
                        end
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= t_cnt'(MaxPoints)) else $error("stack over capacity");
    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= t_cnt'(MaxPoints)) else $error("point count over capacity");
    a_take_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_take |-> r_st == S_LOAD) else $error("queue read outside load");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_pop |=> r_out_v && $stable(r_ox) && $stable(r_olast))
        else $error("result changed while waiting");
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import chgs_pkg::*;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
        logic   hold;
    } t_point_req;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
        logic   ovf;
    } t_vertex;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   push = 1'b0;
    logic   pop = 1'b0;
    t_coord i_point_x = '0;
    t_coord i_point_y = '0;
    logic   i_last_point = 1'b0;
    logic   full, empty, o_hull_last, o_overflow;
    t_coord o_hull_x, o_hull_y;

    t_point_req point_reqs[$];
    t_vertex    hull_expected[$];
    int         n_errors = 0;

    // shadow of the hull engine
    longint pts_x[MaxPoints];
    longint pts_y[MaxPoints];
    int     pts_count = 0;
    logic   pts_dropped = 1'b0;
    longint piv_x, piv_y;
    int     sort_idx[MaxPoints];
    int     hull_idx[MaxPoints];

    convex_hull_graham_scan_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_last_point(i_last_point),
        .empty       (empty),
        .pop         (pop),
        .o_hull_x    (o_hull_x),
        .o_hull_y    (o_hull_y),
        .o_hull_last (o_hull_last),
        .o_overflow  (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint turn(longint ox, longint oy, int a, int b);
        return (pts_x[a] - ox) * (pts_y[b] - oy) - (pts_y[a] - oy) * (pts_x[b] - ox);
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // angle about the pivot first, nearer first on equal angle
    function automatic bit angle_before(int a, int b);
        longint c;
        c = turn(piv_x, piv_y, a, b);
        if (c != 0)
            return c > 0;
        return labs(pts_x[a] - piv_x) + labs(pts_y[a] - piv_y)
             < labs(pts_x[b] - piv_x) + labs(pts_y[b] - piv_y);
    endfunction

    function automatic void hull_accept(t_point_req r);
        int      piv, nsort, depth, i, j, p, a, b;
        t_vertex v;
        if (pts_count < MaxPoints) begin
            pts_x[pts_count] = longint'(r.x);
            pts_y[pts_count] = longint'(r.y);
            pts_count++;
        end else begin
            pts_dropped = 1'b1;
        end
        if (!r.last)
            return;
        piv = 0;
        for (i = 1; i < pts_count; i++)
            if (pts_y[i] < pts_y[piv] || (pts_y[i] == pts_y[piv] && pts_x[i] > pts_x[piv]))
                piv = i;
        piv_x = pts_x[piv];
        piv_y = pts_y[piv];
        nsort = 0;
        for (i = 0; i < pts_count; i++) begin
            if (pts_x[i] == piv_x && pts_y[i] == piv_y)
                continue;
            j = nsort;
            while (j > 0 && angle_before(i, sort_idx[j-1])) begin
                sort_idx[j] = sort_idx[j-1];
                j--;
            end
            sort_idx[j] = i;
            nsort++;
        end
        depth = 1;
        hull_idx[0] = piv;
        for (i = 0; i < nsort; i++) begin
            p = sort_idx[i];
            while (depth >= 2) begin
                a = hull_idx[depth-2];
                b = hull_idx[depth-1];
                if (turn(pts_x[a], pts_y[a], b, p) > 0)
                    break;
                depth--;
            end
            if (depth < MaxPoints) begin
                hull_idx[depth] = p;
                depth++;
            end
        end
        for (i = 0; i < depth; i++) begin
            v.x = t_coord'(pts_x[hull_idx[i]]);
            v.y = t_coord'(pts_y[hull_idx[i]]);
            v.last = (i == depth - 1);
            v.ovf = pts_dropped;
            hull_expected.push_back(v);
        end
        pts_count = 0;
        pts_dropped = 1'b0;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: MISMATCH %s", $realtime, what);
        n_errors++;
    endtask

    // driver: bursts with random gaps; optional hold-off until all vertices are back
    int   burst_left = 0;
    int   gap_left = 0;
    logic drained = 1'b0;
    logic next_push;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                hull_accept(point_reqs.pop_front());
                drained = 1'b0;
            end
            next_push = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (point_reqs.size() != 0) begin
                if (point_reqs[0].hold && !drained && hull_expected.size() != 0) begin
                    next_push = 1'b0;
                end else begin
                    drained = 1'b1;
                    next_push = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                    end else begin
                        burst_left--;
                        if (burst_left == 0)
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            push <= next_push;
            if (next_push) begin
                i_point_x    <= point_reqs[0].x;
                i_point_y    <= point_reqs[0].y;
                i_last_point <= point_reqs[0].last;
            end
        end
    end

    // monitor: receiver stall mode changes every so often
    int stall_mode = 0;
    int mode_left = 0;
    t_vertex got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (hull_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected vertex (%0d,%0d)", o_hull_x, o_hull_y));
                end else begin
                    got = hull_expected.pop_front();
                    if (o_hull_x !== got.x)
                        report_mismatch($sformatf("hull_x %0d exp %0d", o_hull_x, got.x));
                    if (o_hull_y !== got.y)
                        report_mismatch($sformatf("hull_y %0d exp %0d", o_hull_y, got.y));
                    if (o_hull_last !== got.last)
                        report_mismatch($sformatf("hull_last %b exp %b", o_hull_last, got.last));
                    if (o_overflow !== got.ovf)
                        report_mismatch($sformatf("overflow %b exp %b", o_overflow, got.ovf));
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                default: pop <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic add_point(int x, int y, logic last, logic hold = 1'b0);
        t_point_req r;
        r.x = t_coord'(x);
        r.y = t_coord'(y);
        r.last = last;
        r.hold = hold;
        point_reqs.push_back(r);
    endtask

    // kind 0: full range, 1: small grid (duplicates, collinear), 2: one line
    task automatic add_set(int n, int kind, logic hold = 1'b0);
        int i, ox, oy, dx, dy, k;
        ox = $urandom_range(0, 200) - 100;
        oy = $urandom_range(0, 200) - 100;
        dx = $urandom_range(0, 6) - 3;
        dy = $urandom_range(0, 6) - 3;
        for (i = 0; i < n; i++) begin
            k = $urandom_range(0, 40) - 20;
            case (kind)
                0: add_point($urandom_range(0, 65535) - 32768,
                             $urandom_range(0, 65535) - 32768, i == n - 1, hold && i == 0);
                1: add_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                             i == n - 1, hold && i == 0);
                default: add_point(ox + k * dx, oy + k * dy, i == n - 1, hold && i == 0);
            endcase
        end
    endtask

    int n_rand;
    int sz;

    initial begin
        // corners of the coordinate range with an interior point
        add_point(-32768, -32768, 0);
        add_point(32767, -32768, 0);
        add_point(32767, 32767, 0);
        add_point(-32768, 32767, 0);
        add_point(0, 0, 1);
        // all points equal
        add_point(5, 5, 0);
        add_point(5, 5, 0);
        add_point(5, 5, 1);
        // all collinear
        add_point(0, 0, 0);
        add_point(3, 3, 0);
        add_point(1, 1, 0);
        add_point(2, 2, 1);
        // single point
        add_point(-7, 9, 1);
        // duplicates of a bottom-edge point beside the pivot (2,-5), a collinear edge point
        add_point(0, -5, 0);
        add_point(0, -5, 0);
        add_point(4, 0, 0);
        add_point(0, -5, 0);
        add_point(-4, 0, 0);
        add_point(2, -5, 0);
        add_point(-2, 3, 0);
        add_point(0, 6, 1);

        n_rand = 21;
        add_set(6, 0, 1'b1);
        n_rand += 6;
        // overfull sets: each has its last point itself dropped
        add_set(66, 0);
        add_set(70, 1);
        n_rand += 136;
        while (n_rand < 380) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            add_set(sz, $urandom_range(0, 2));
            n_rand += sz;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (point_reqs.size() == 0);
        wait (hull_expected.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0)
            $display("convex_hull_graham_scan_unit test passed");
        else
            $display("convex_hull_graham_scan_unit test failed");
        $finish;
    end

    initial begin
        #10ms;
        $display("convex_hull_graham_scan_unit test failed");
        $finish;
    end

endmodule
